/* rtl/md5md_pkg.sv */
// md5md_pkg: shared types, constants and round functions for the MD5 digest block.
// No dependencies; every other file in rtl/ refers to it by scoped names.

package md5md_pkg;

  // Request and result payloads
  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } in_req_t;

  typedef struct packed {
    logic [63:0] digest_high;
    logic [63:0] digest_low;
  } out_res_t;

  // Initial chaining words and padding constants
  localparam logic [31:0] IV_A     = 32'h67452301;
  localparam logic [31:0] IV_B     = 32'hefcdab89;
  localparam logic [31:0] IV_C     = 32'h98badcfe;
  localparam logic [31:0] IV_D     = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS  = 6'd56;
  localparam logic [5:0]  LAST_IDX = 6'h3F;
  localparam logic [5:0]  LAST_RND = 6'h3F;

  localparam logic [31:0] STEP_CONST [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMOUNT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22, 5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23, 5'd6, 5'd10, 5'd15, 5'd21
  };

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FOLD,
    ST_DIGEST
  } state_e;

  // What the block buffer holds for the compression in flight
  typedef enum logic [1:0] {
    KIND_DATA,     // 64 message bytes
    KIND_PAD,      // message bytes, 0x80, zeros; length follows in another block
    KIND_PAD_LEN,  // message bytes, 0x80, zeros, bit length
    KIND_LEN       // zeros and bit length
  } blk_kind_e;

  // Controller to datapath
  typedef struct packed {
    logic       wr_byte;
    logic [7:0] data_byte;
    logic       load_work;
    logic       round_en;
    logic [5:0] round;
    blk_kind_e  kind;
    logic       fold;
    logic       finish;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [5:0] fill;
  } dp_sts_t;

  function automatic logic [3:0] msg_index(input logic [5:0] k);
    logic [3:0] idx;
    case (k[5:4])
      2'd0:    idx = k[3:0];
      2'd1:    idx = 4'(k[3:0] * 4'd5 + 4'd1);
      2'd2:    idx = 4'(k[3:0] * 4'd3 + 4'd5);
      default: idx = 4'(k[3:0] * 4'd7);
    endcase
    return idx;
  endfunction

  function automatic logic [31:0] round_fn(input logic [1:0] rnd, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] dbl;
    dbl = {x, x} << s;
    return dbl[63:32];
  endfunction

  // Present the stored word with padding and length bytes laid over it
  function automatic logic [31:0] shape_word(input logic [31:0] raw, input logic [3:0] widx,
                                             input blk_kind_e kind, input logic [5:0] fill,
                                             input logic [63:0] count);
    logic [31:0] w;
    logic [5:0]  p;
    logic        msg_ok;
    logic        pad_ok;
    logic        len_ok;
    w = '0;
    for (int j = 0; j < 4; j++) begin
      p      = {widx, 2'(j)};
      msg_ok = (kind == KIND_DATA) ||
               ((kind == KIND_PAD || kind == KIND_PAD_LEN) && (p < fill));
      pad_ok = (kind == KIND_PAD || kind == KIND_PAD_LEN) && (p == fill);
      len_ok = (kind == KIND_PAD_LEN || kind == KIND_LEN) && (p >= LEN_POS);
      if (msg_ok) begin
        w[8*j +: 8] = raw[8*j +: 8];
      end else if (pad_ok) begin
        w[8*j +: 8] = PAD_BYTE;
      end else if (len_ok) begin
        w[8*j +: 8] = count[{p[2:0], 3'b000} +: 8];
      end
    end
    return w;
  endfunction

endpackage

/* rtl/md5md_dp.sv */
// md5md_dp: block buffer, bit counter, chaining value, round unit and result register.
// Depends on md5md_pkg; driven by md5md_ctrl through dp_cmd_t.

module md5md_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  md5md_pkg::dp_cmd_t  cmd_i,
  output md5md_pkg::dp_sts_t  sts_o,
  output md5md_pkg::out_res_t res_o
);

  logic [31:0] wrd_q [16];
  logic [63:0] count_q, count_d;
  logic [31:0] cv_q [4];
  logic [31:0] cv_d [4];
  logic [31:0] a_q, b_q, c_q, d_q;
  logic [31:0] a_d, b_d, c_d, d_d;
  md5md_pkg::out_res_t res_q;

  logic [5:0]  fill;
  logic [3:0]  g;
  logic [31:0] w_shaped;
  logic [31:0] f;
  logic [31:0] sum;
  logic [31:0] b_new;

  assign fill     = count_q[8:3];
  assign g        = md5md_pkg::msg_index(cmd_i.round);
  assign w_shaped = md5md_pkg::shape_word(wrd_q[g], g, cmd_i.kind, fill, count_q);
  assign f        = md5md_pkg::round_fn(cmd_i.round[5:4], b_q, c_q, d_q);
  assign sum      = a_q + f + md5md_pkg::STEP_CONST[cmd_i.round] + w_shaped;
  assign b_new    = b_q + md5md_pkg::rotl32(sum,
                      md5md_pkg::ROT_AMOUNT[{cmd_i.round[5:4], cmd_i.round[1:0]}]);

  always_comb begin
    count_d = count_q;
    cv_d    = cv_q;
    a_d     = a_q;
    b_d     = b_q;
    c_d     = c_q;
    d_d     = d_q;
    if (cmd_i.wr_byte) begin
      count_d = count_q + 64'd8;
    end
    if (cmd_i.load_work) begin
      a_d = cv_q[0];
      b_d = cv_q[1];
      c_d = cv_q[2];
      d_d = cv_q[3];
    end else if (cmd_i.round_en) begin
      a_d = d_q;
      b_d = b_new;
      c_d = b_q;
      d_d = c_q;
    end else if (cmd_i.fold) begin
      // fold into the chaining value and seed the next block with it
      cv_d[0] = cv_q[0] + a_q;
      cv_d[1] = cv_q[1] + b_q;
      cv_d[2] = cv_q[2] + c_q;
      cv_d[3] = cv_q[3] + d_q;
      a_d     = cv_d[0];
      b_d     = cv_d[1];
      c_d     = cv_d[2];
      d_d     = cv_d[3];
    end
    if (cmd_i.finish) begin
      cv_d[0] = md5md_pkg::IV_A;
      cv_d[1] = md5md_pkg::IV_B;
      cv_d[2] = md5md_pkg::IV_C;
      cv_d[3] = md5md_pkg::IV_D;
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cv_q[0] <= md5md_pkg::IV_A;
      cv_q[1] <= md5md_pkg::IV_B;
      cv_q[2] <= md5md_pkg::IV_C;
      cv_q[3] <= md5md_pkg::IV_D;
    end else begin
      count_q <= count_d;
      cv_q    <= cv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
    if (cmd_i.wr_byte) begin
      wrd_q[fill[5:2]][{fill[1:0], 3'b000} +: 8] <= cmd_i.data_byte;
    end
    if (cmd_i.finish) begin
      res_q.digest_low  <= {cv_q[1], cv_q[0]};
      res_q.digest_high <= {cv_q[3], cv_q[2]};
    end
  end

  assign sts_o.fill = fill;
  assign res_o      = res_q;

endmodule

/* rtl/md5md_ctrl.sv */
// md5md_ctrl: sequencer for byte intake, padding, the 64 rounds and result hand-off.
// Depends on md5md_pkg; commands md5md_dp through dp_cmd_t.

module md5md_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  md5md_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output md5md_pkg::dp_cmd_t  cmd_o,
  input  md5md_pkg::dp_sts_t  sts_i
);

  md5md_pkg::state_e    state_q, state_d;
  md5md_pkg::blk_kind_e kind_q, kind_d;
  logic [5:0]           round_q, round_d;
  logic                 last_pend_q, last_pend_d;
  logic                 out_valid_q, out_valid_d;

  logic accept;
  logic blk_full;
  logic out_free;

  assign in_stall_o = (state_q != md5md_pkg::ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign blk_full   = in_req_i.has_byte && (sts_i.fill == md5md_pkg::LAST_IDX);
  assign out_free   = !out_valid_q || !out_stall_i;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      md5md_pkg::ST_IDLE: begin
        if (accept && blk_full) begin
          state_d = md5md_pkg::ST_ROUND;
        end else if (accept && in_req_i.last) begin
          state_d = md5md_pkg::ST_PAD;
        end
      end
      md5md_pkg::ST_PAD: begin
        state_d = md5md_pkg::ST_ROUND;
      end
      md5md_pkg::ST_ROUND: begin
        if (round_q == md5md_pkg::LAST_RND) begin
          state_d = md5md_pkg::ST_FOLD;
        end
      end
      md5md_pkg::ST_FOLD: begin
        case (kind_q)
          md5md_pkg::KIND_DATA: begin
            state_d = last_pend_q ? md5md_pkg::ST_PAD : md5md_pkg::ST_IDLE;
          end
          md5md_pkg::KIND_PAD: begin
            state_d = md5md_pkg::ST_ROUND;
          end
          default: begin
            state_d = md5md_pkg::ST_DIGEST;
          end
        endcase
      end
      md5md_pkg::ST_DIGEST: begin
        if (out_free) begin
          state_d = md5md_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = md5md_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands and register updates
  always_comb begin
    cmd_o           = '0;
    cmd_o.round     = round_q;
    cmd_o.kind      = kind_q;
    cmd_o.data_byte = in_req_i.data_byte;
    kind_d          = kind_q;
    round_d         = round_q;
    last_pend_d     = last_pend_q;
    out_valid_d     = out_valid_q && out_stall_i;
    case (state_q)
      md5md_pkg::ST_IDLE: begin
        cmd_o.wr_byte = accept && in_req_i.has_byte;
        if (accept && blk_full) begin
          cmd_o.load_work = 1'b1;
          kind_d          = md5md_pkg::KIND_DATA;
          round_d         = '0;
          last_pend_d     = in_req_i.last;
        end
      end
      md5md_pkg::ST_PAD: begin
        cmd_o.load_work = 1'b1;
        kind_d          = (sts_i.fill >= md5md_pkg::LEN_POS) ? md5md_pkg::KIND_PAD
                                                             : md5md_pkg::KIND_PAD_LEN;
        round_d         = '0;
        last_pend_d     = 1'b0;
      end
      md5md_pkg::ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        round_d        = round_q + 6'd1;
      end
      md5md_pkg::ST_FOLD: begin
        cmd_o.fold = 1'b1;
        if (kind_q == md5md_pkg::KIND_PAD) begin
          kind_d  = md5md_pkg::KIND_LEN;
          round_d = '0;
        end
      end
      md5md_pkg::ST_DIGEST: begin
        if (out_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= md5md_pkg::ST_IDLE;
      kind_q      <= md5md_pkg::KIND_DATA;
      round_q     <= '0;
      last_pend_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      kind_q      <= kind_d;
      round_q     <= round_d;
      last_pend_q <= last_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/md5_message_digest.sv */
// md5_message_digest: MD5 over a byte stream, at most one byte per request, digest on last.
// Intake: a request that does not complete a 64-byte block is taken while idle; the 64th byte
//   holds the input stalled through the 64 rounds and the fold.
// Last: a pad step, then rounds and fold for each padded block (1 or 2 blocks), then the result
//   register is loaded once the output side is free.
// Reset: rst_ni asynchronous, active low; restores the initial chaining words, zero bit count.

module md5_message_digest (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  md5md_pkg::in_req_t  in_req_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output md5md_pkg::out_res_t out_res_o
);

  // Controller decides what the datapath does each cycle; the datapath reports the
  // byte position inside the current block so the controller knows when it fills.
  md5md_pkg::dp_cmd_t dp_cmd;
  md5md_pkg::dp_sts_t dp_sts;

  md5md_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (dp_cmd),
    .sts_i       (dp_sts)
  );

  // Datapath: byte buffer with padding laid over on read, one MD5 step per cycle,
  // and the result register that holds the digest while the consumer stalls.
  md5md_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (dp_cmd),
    .sts_o  (dp_sts),
    .res_o  (out_res_o)
  );

endmodule

/* rtl/md5md_checker.sv */
// md5md_checker: port-level checks for md5_message_digest, attached by bind.
// Depends on md5md_pkg for the payload types.

module md5md_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input md5md_pkg::in_req_t  in_req_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input md5md_pkg::out_res_t out_res_o
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_res_o))
    else $error("stalled result changed");

  // closing a message always takes the input side busy for padding
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_req_i.last |=> in_stall_o)
    else $error("input taken right after closing request");

  // a new digest appears only out of a busy finalization
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("digest appeared without finalization");

endmodule

bind md5_message_digest md5md_checker u_md5md_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_res_o   (out_res_o)
);

/* sim/md5_message_digest_test.sv */
`timescale 1ns / 100ps
// md5_message_digest_test: self-checking testbench for the streaming MD5 digest block.
// Carries its own MD5 predictor; depends on md5md_pkg and md5_message_digest only.

module md5_message_digest_test;

  // Run sizing
  localparam int unsigned ITEM_TARGET  = 1700;
  localparam int unsigned HOLD_CYCLES  = 1500;
  localparam int unsigned IDLE_LIMIT   = 5000;
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned REPORT_CAP   = 100;

  // MD5 padding layout
  localparam logic [7:0]  PAD_MARK  = 8'h80;
  localparam int unsigned LEN_FIELD = 56;

  localparam logic [31:0] INIT_WORDS [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] SINE_TABLE [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // Rotate amounts, four per round
  localparam int unsigned SHIFT_TABLE [16] = '{
    7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
  };

  // Published digests of the empty string and of "abc", packed as the block emits them
  localparam logic [63:0] EMPTY_LOW  = 64'h04b2008fd98c1dd4;
  localparam logic [63:0] EMPTY_HIGH = 64'h7e42f8ec980980e9;
  localparam logic [63:0] ABC_LOW    = 64'hb04fd23c98500190;
  localparam logic [63:0] ABC_HIGH   = 64'h727fe1287d3f96d6;

  // Message lengths around the one-block / two-block padding split
  localparam int unsigned EDGE_LENGTHS [10] = '{55, 56, 57, 63, 64, 65, 119, 120, 127, 128};

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  md5md_pkg::in_req_t  in_req;
  logic                out_valid;
  logic                out_stall;
  md5md_pkg::out_res_t out_res;

  // Predictor state: chaining words, block buffer and running bit length
  logic [31:0]         chain_words [4];
  logic [7:0]          block_bytes [64];
  logic [63:0]         message_bits;
  md5md_pkg::out_res_t expected_digests [$];

  // Traffic shaping shared between the test tasks and the two drivers
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned burst_left;
  int unsigned gap_max;
  int unsigned stall_pct;
  logic        long_hold;
  logic        hold_done;

  md5_message_digest uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_res_o   (out_res)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // MD5 predictor
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rotate_left(input logic [31:0] v, input int unsigned n);
    return (n == 0) ? v : ((v << n) | (v >> (32 - n)));
  endfunction

  // Run the 64 steps over the buffered block and fold into the chaining words
  function automatic void md5_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g;
    int unsigned rnd;
    for (int k = 0; k < 16; k++) begin
      w[k] = {block_bytes[4*k+3], block_bytes[4*k+2], block_bytes[4*k+1], block_bytes[4*k]};
    end
    a = chain_words[0];
    b = chain_words[1];
    c = chain_words[2];
    d = chain_words[3];
    for (int k = 0; k < 64; k++) begin
      rnd = k / 16;
      case (rnd)
        0: begin
          f = (b & c) | (~b & d);
          g = k;
        end
        1: begin
          f = (b & d) | (c & ~d);
          g = (5 * k + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * k + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * k) % 16;
        end
      endcase
      t = d;
      d = c;
      c = b;
      b = b + rotate_left(a + f + SINE_TABLE[k] + w[g], SHIFT_TABLE[rnd * 4 + k % 4]);
      a = t;
    end
    chain_words[0] += a;
    chain_words[1] += b;
    chain_words[2] += c;
    chain_words[3] += d;
  endfunction

  function automatic void md5_restart();
    for (int k = 0; k < 4; k++) chain_words[k] = INIT_WORDS[k];
    message_bits = '0;
  endfunction

  // Absorb one accepted request; on last, pad, finish and queue the digest
  function automatic void md5_take_request(input md5md_pkg::in_req_t req);
    int unsigned         pos;
    md5md_pkg::out_res_t digest;
    if (req.has_byte) begin
      pos = 32'(message_bits[8:3]);
      block_bytes[pos] = req.data_byte;
      message_bits += 64'd8;
      if (pos == 63) md5_compress();
    end
    if (req.last) begin
      pos = 32'(message_bits[8:3]);
      block_bytes[pos] = PAD_MARK;
      pos++;
      // no room left for the length: close this block and pad a fresh one
      if (pos > LEN_FIELD) begin
        for (int k = pos; k < 64; k++) block_bytes[k] = 8'h00;
        md5_compress();
        pos = 0;
      end
      for (int k = pos; k < LEN_FIELD; k++) block_bytes[k] = 8'h00;
      for (int k = 0; k < 8; k++) block_bytes[LEN_FIELD + k] = message_bits[8*k +: 8];
      md5_compress();
      digest.digest_low  = {chain_words[1], chain_words[0]};
      digest.digest_high = {chain_words[3], chain_words[2]};
      expected_digests.push_back(digest);
      md5_restart();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    if (mismatches < REPORT_CAP) begin
      $display("%0t: %s expected %016h got %016h", $time, what, want, got);
    end
    mismatches++;
  endtask

  // Compare each accepted digest with the oldest one predicted
  always @(posedge clk) begin : digest_checker
    md5md_pkg::out_res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_digests.size() == 0) begin
        report_mismatch("digest with no message closed, digest_low", '0, out_res.digest_low);
      end else begin
        want = expected_digests.pop_front();
        if (out_res.digest_low !== want.digest_low) begin
          report_mismatch("digest_low", want.digest_low, out_res.digest_low);
        end
        if (out_res.digest_high !== want.digest_high) begin
          report_mismatch("digest_high", want.digest_high, out_res.digest_high);
        end
      end
    end
  end

  // Sanity-check the predictor against a published digest
  task automatic check_known_digest(input logic [63:0] low, input logic [63:0] high);
    md5md_pkg::out_res_t newest;
    newest = expected_digests[expected_digests.size() - 1];
    if (newest.digest_low !== low) report_mismatch("known digest_low", low, newest.digest_low);
    if (newest.digest_high !== high) begin
      report_mismatch("known digest_high", high, newest.digest_high);
    end
  endtask

  // End the run when nothing moves on either channel for too long
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("md5_message_digest_test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Result side: random stall runs, or one long hold when a test asks for it
  initial begin : result_receiver
    logic        stalling;
    int unsigned run_left;
    int unsigned hold_count;
    out_stall  = 1'b0;
    hold_done  = 1'b0;
    stalling   = 1'b0;
    run_left   = 0;
    hold_count = 0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        if (hold_count < HOLD_CYCLES) begin
          hold_count++;
          out_stall <= 1'b1;
        end else begin
          hold_done = 1'b1;
          out_stall <= 1'b0;
        end
      end else begin
        hold_count = 0;
        hold_done  = 1'b0;
        if (run_left == 0) begin
          run_left = $urandom_range(1, 20);
          stalling = ($urandom_range(0, 99) < stall_pct);
        end
        run_left--;
        out_stall <= stalling;
      end
    end
  end

  function automatic md5md_pkg::in_req_t make_req(input logic [7:0] data,
                                                  input logic has_byte, input logic last);
    md5md_pkg::in_req_t req;
    req.data_byte = data;
    req.has_byte  = has_byte;
    req.last      = last;
    return req;
  endfunction

  // Offer one request in bursts; hold it until accepted, then feed the predictor
  task automatic send_request(input md5md_pkg::in_req_t req);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      if (gap_max != 0) gap = $urandom_range(1, gap_max);
    end
    burst_left--;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_req   <= req;
    do @(posedge clk); while (in_stall);
    md5_take_request(req);
    if (req.has_byte || req.last) items_sent++;
  endtask

  // Drop valid right after the last accepted request
  task automatic sender_pause();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // One message of random bytes, closed either on its last byte or by a bare last
  task automatic send_message(input int unsigned len);
    logic joined;
    joined = (len != 0) && ($urandom_range(0, 1) == 1);
    for (int unsigned i = 0; i < len; i++) begin
      // sprinkle requests that carry nothing
      if ($urandom_range(0, 19) == 0) send_request(make_req(8'($urandom), 1'b0, 1'b0));
      send_request(make_req(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1)));
    end
    if (!joined) send_request(make_req(8'($urandom), 1'b0, 1'b1));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty message, byte and last together, an empty request mid-message, byte extremes
  task automatic test_known_answers();
    gap_max   = 3;
    stall_pct = 0;
    send_request(make_req(8'hFF, 1'b0, 1'b1));
    check_known_digest(EMPTY_LOW, EMPTY_HIGH);
    send_request(make_req(8'h61, 1'b1, 1'b0));
    send_request(make_req(8'h5A, 1'b0, 1'b0));
    send_request(make_req(8'h62, 1'b1, 1'b0));
    send_request(make_req(8'h63, 1'b1, 1'b1));
    check_known_digest(ABC_LOW, ABC_HIGH);
    send_request(make_req(8'h00, 1'b1, 1'b0));
    send_request(make_req(8'hFF, 1'b1, 1'b0));
    send_request(make_req(8'h00, 1'b0, 1'b1));
    send_request(make_req(8'hFF, 1'b1, 1'b1));
    send_request(make_req(8'h00, 1'b1, 1'b1));
    send_request(make_req(8'h00, 1'b0, 1'b1));
  endtask

  // Lengths where padding fits in the last block or spills into another
  task automatic test_block_boundaries();
    gap_max   = 6;
    stall_pct = 30;
    for (int i = 0; i < 10; i++) send_message(EDGE_LENGTHS[i]);
  endtask

  // Hold the result side off so the block fills and stalls its input,
  // then stop sending until every digest has drained
  task automatic test_output_backpressure();
    gap_max   = 0;
    stall_pct = 0;
    long_hold = 1'b1;
    repeat (12) send_message($urandom_range(0, 3));
    while (!hold_done) @(posedge clk);
    long_hold = 1'b0;
    sender_pause();
    while (expected_digests.size() != 0) @(posedge clk);
  endtask

  // Random messages, biased to short ones and to lengths near block edges;
  // one stretch in the middle runs with no idling on either side
  task automatic test_random_messages();
    int unsigned roll;
    int unsigned len;
    logic        quiet;
    while (items_sent < ITEM_TARGET) begin
      quiet     = (items_sent > 700) && (items_sent < 1000);
      gap_max   = quiet ? 0 : 8;
      stall_pct = quiet ? 0 : 40;
      roll      = $urandom_range(0, 99);
      if (roll < 70) begin
        len = $urandom_range(0, 8);
      end else if (roll < 90) begin
        len = 64 * $urandom_range(0, 1) + $urandom_range(53, 66);
      end else begin
        len = $urandom_range(0, 200);
      end
      send_message(len);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_req     = '0;
    long_hold  = 1'b0;
    mismatches = 0;
    items_sent = 0;
    burst_left = 0;
    gap_max    = 0;
    stall_pct  = 0;
    for (int k = 0; k < 64; k++) block_bytes[k] = 8'h00;
    md5_restart();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    test_known_answers();
    test_block_boundaries();
    test_output_backpressure();
    test_random_messages();

    // drain: wait for the last digests, then give the block time to misbehave
    sender_pause();
    while (expected_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("md5_message_digest_test passed");
    end else begin
      $display("md5_message_digest_test failed");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/md5md_pkg.sv
rtl/md5md_dp.sv
rtl/md5md_ctrl.sv
rtl/md5_message_digest.sv
rtl/md5md_checker.sv
sim/md5_message_digest_test.sv
